// ===== rtl/mos_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mos_pkg
// Shared types for the median-of-set block.
// ----------------------------------------------------------------------------
package mos_pkg;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CAND,
    S_LATCH,
    S_SCAN,
    S_CHECK,
    S_OUT
  } mos_state_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 9;

endpackage

// ===== rtl/median_of_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_of_set
// Collects a set of signed Q16.16 values in a local memory and returns the
// median after the last value of the set, by rank counting over the store.
// ----------------------------------------------------------------------------
// Loading: one value per cycle while busy is low; a value that does not fit
// in the store is dropped and the overflow flag is raised.
// Selection: for a set of n values each candidate goes through fetch, latch,
// an n-entry scan of the single memory port and a rank check, with busy high;
// up to n candidates are tried before the result. The result strobe is
// registered from the output state that follows the rank check; the receiver
// cannot stall it. Synchronous active-low reset clears the count, flag and
// state; the store itself needs no clearing.
module median_of_set #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [mos_pkg::VALUE_W-1:0]    in_sample_value,
  input  logic                                  in_last_of_set,
  output logic                                  out_valid,
  output logic signed [mos_pkg::VALUE_W-1:0]    out_median_value,
  output logic        [mos_pkg::COUNT_W-1:0]    out_set_count,
  output logic                                  out_overflow
);

  import mos_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] FULL = CW'(MAX_ITEMS);

  mos_state_t state_r, state_nxt;

  logic [CW-1:0] kept_r, kept_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] cand_r, cand_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic [CW-1:0] lt_r, lt_nxt;
  logic [CW-1:0] eq_r, eq_nxt;
  logic          cmp_vld_r, cmp_vld_nxt;
  logic          found_lo_r, found_lo_nxt;
  logic          found_hi_r, found_hi_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic signed [VALUE_W-1:0] lo_r, lo_nxt;
  logic signed [VALUE_W-1:0] hi_r, hi_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_med_r, out_med_nxt;
  logic [COUNT_W-1:0]        out_cnt_r, out_cnt_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  // store
  logic [VALUE_W-1:0] mem [MAX_ITEMS];
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic signed [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= in_sample_value;
    end
    rd_data_r <= mem[mem_addr];
  end

  logic                      accept;
  logic [CW-1:0]             half;
  logic [CW-1:0]             k_lo;
  logic [CW:0]               rank_le;
  logic                      hit_lo, hit_hi;
  logic signed [VALUE_W:0]   pair_sum;
  logic [CW+COUNT_W-1:0]     kept_ext;

  assign accept   = start && (state_r == S_LOAD);
  assign half     = kept_r >> 1;
  assign k_lo     = kept_r[0] ? half : half - CW'(1);
  assign rank_le  = {1'b0, lt_r} + {1'b0, eq_r};
  assign hit_lo   = (lt_r <= k_lo) && ({1'b0, k_lo} < rank_le);
  assign hit_hi   = (lt_r <= half) && ({1'b0, half} < rank_le);
  assign pair_sum = {lo_r[VALUE_W-1], lo_r} + {hi_r[VALUE_W-1], hi_r};
  assign kept_ext = {{COUNT_W{1'b0}}, kept_r};

  always_comb begin
    state_nxt     = state_r;
    kept_nxt      = kept_r;
    dropped_nxt   = dropped_r;
    cand_nxt      = cand_r;
    scan_nxt      = scan_r;
    lt_nxt        = lt_r;
    eq_nxt        = eq_r;
    cmp_vld_nxt   = 1'b0;
    found_lo_nxt  = found_lo_r;
    found_hi_nxt  = found_hi_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = 1'b0;
    out_med_nxt   = out_med_r;
    out_cnt_nxt   = out_cnt_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_addr      = kept_r[AW-1:0];

    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (kept_r < FULL) begin
            mem_we   = 1'b1;
            kept_nxt = kept_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last_of_set) begin
            state_nxt    = S_CAND;
            cand_nxt     = '0;
            found_lo_nxt = 1'b0;
            found_hi_nxt = 1'b0;
          end
        end
      end
      S_CAND: begin
        mem_addr  = cand_r[AW-1:0];
        state_nxt = S_LATCH;
      end
      S_LATCH: begin
        // candidate arrives; start the scan at entry zero
        key_nxt     = rd_data_r;
        mem_addr    = '0;
        scan_nxt    = CW'(1);
        cmp_vld_nxt = 1'b1;
        lt_nxt      = '0;
        eq_nxt      = '0;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        mem_addr = scan_r[AW-1:0];
        if (cmp_vld_r) begin
          if (rd_data_r < key_r) begin
            lt_nxt = lt_r + CW'(1);
          end else if (rd_data_r == key_r) begin
            eq_nxt = eq_r + CW'(1);
          end
        end
        if (scan_r < kept_r) begin
          scan_nxt    = scan_r + CW'(1);
          cmp_vld_nxt = 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit_lo) begin
          lo_nxt       = key_r;
          found_lo_nxt = 1'b1;
        end
        if (hit_hi) begin
          hi_nxt       = key_r;
          found_hi_nxt = 1'b1;
        end
        if ((found_lo_r || hit_lo) && (found_hi_r || hit_hi)) begin
          state_nxt = S_OUT;
        end else begin
          cand_nxt  = cand_r + CW'(1);
          state_nxt = S_CAND;
        end
      end
      S_OUT: begin
        // floor of the mean; for an odd count both halves hold the same value
        out_valid_nxt = 1'b1;
        out_med_nxt   = VALUE_W'(pair_sum >>> 1);
        out_cnt_nxt   = kept_ext[COUNT_W-1:0];
        out_ovf_nxt   = dropped_r;
        kept_nxt      = '0;
        dropped_nxt   = 1'b0;
        state_nxt     = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      kept_r      <= '0;
      dropped_r   <= 1'b0;
      cmp_vld_r   <= 1'b0;
      found_lo_r  <= 1'b0;
      found_hi_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_r      <= kept_nxt;
      dropped_r   <= dropped_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      found_lo_r  <= found_lo_nxt;
      found_hi_r  <= found_hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r    <= cand_nxt;
    scan_r    <= scan_nxt;
    lt_r      <= lt_nxt;
    eq_r      <= eq_nxt;
    key_r     <= key_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    out_med_r <= out_med_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign busy             = (state_r != S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;
  assign out_set_count    = out_cnt_r;
  assign out_overflow     = out_ovf_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && (kept_r == '0 || $past(accept)))
    else $error("result strobe while selection active");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (rank_le <= {1'b0, kept_r}))
    else $error("rank count exceeds set size");

  a_drop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kept_r == FULL && !in_last_of_set) |=> dropped_r)
    else $error("dropped value not flagged");

  a_select_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CAND) |-> (kept_r != '0) && (cand_r < kept_r))
    else $error("candidate index outside kept set");

endmodule
